[sv/sca_pkg.sv]
// Shared types, constants and arithmetic step functions for the shadow corner alpha block.
package sca_pkg;

  // Largest tile edge and radius; larger register values saturate to this.
  localparam int unsigned MAX_TILE = 128;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] REG_TILE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_TILE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_CORNER_RADIUS = 2'd2;

  // Pipeline shape: two root bits per square-root stage, two quotient bits per divide stage.
  localparam int unsigned SQ_STAGES  = 8;
  localparam int unsigned DIV_STAGES = 4;

  // Saturated configuration handed to the datapath.
  typedef struct packed {
    logic [7:0] width;
    logic [7:0] height;
    logic [7:0] radius;
  } sca_cfg_t;

  // Partial state of the digit-by-digit square root.
  typedef struct packed {
    logic [17:0] rem;
    logic [15:0] root;
  } sca_sq_t;

  // Partial state of the restoring divider.
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] quo;
  } sca_dv_t;

  // Clamp a register value to the largest supported tile.
  function automatic logic [7:0] sat_tile(input logic [7:0] v);
    return (v > 8'(MAX_TILE)) ? 8'(MAX_TILE) : v;
  endfunction

  // One root bit: bring down two radicand bits and try to subtract 4*root+1.
  function automatic sca_sq_t sqrt_step(input sca_sq_t cur, input logic [1:0] pair);
    logic [19:0] acc;
    logic [19:0] trial;
    sca_sq_t     res;
    acc   = {cur.rem, pair};
    trial = {2'b00, cur.root, 2'b01};
    if (acc >= trial) begin
      res.rem  = 18'(acc - trial);
      res.root = {cur.root[14:0], 1'b1};
    end else begin
      res.rem  = acc[17:0];
      res.root = {cur.root[14:0], 1'b0};
    end
    return res;
  endfunction

  // One quotient bit: bring down one dividend bit and try to subtract the divisor.
  function automatic sca_dv_t div_step(input sca_dv_t cur, input logic nbit,
                                       input logic [7:0] divisor);
    logic [8:0] acc;
    sca_dv_t    res;
    acc = {cur.rem, nbit};
    if (acc >= {1'b0, divisor}) begin
      res.rem = 8'(acc - {1'b0, divisor});
      res.quo = {cur.quo[6:0], 1'b1};
    end else begin
      res.rem = acc[7:0];
      res.quo = {cur.quo[6:0], 1'b0};
    end
    return res;
  endfunction

endpackage

[sv/sca_pipe.sv]
// Pixel datapath: corner distances, squares, pipelined square root, divide and ease-out.
module sca_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [6:0]          in_col,
  input  logic [6:0]          in_row,
  input  sca_pkg::sca_cfg_t   cfg,
  output logic                out_valid,
  output logic [7:0]          out_alpha
);

  // Stage 1..3: axis distances, squares, sum of squares.
  logic        v1_r, v2_r, v3_r;
  logic [14:0] dx1_r, dy1_r, dx1_nxt, dy1_nxt;
  logic [29:0] dxx2_r, dyy2_r;
  logic [30:0] sum3_r;

  // Square-root stages.
  logic                  sq_v_r    [sca_pkg::SQ_STAGES];
  sca_pkg::sca_sq_t      sq_st_r   [sca_pkg::SQ_STAGES];
  logic [31:0]           sq_val_r  [sca_pkg::SQ_STAGES-1];

  // Radius subtract and range checks.
  logic        sd_v_r, sd_in_r, sd_zero_r;
  logic [14:0] sd_num_r;
  logic [17:0] dist_nxt;
  logic        in_nxt, zero_nxt, blur_pos;
  logic [7:0]  blur_div;

  // Divide stages.
  logic                  dv_v_r    [sca_pkg::DIV_STAGES];
  logic                  dv_in_r   [sca_pkg::DIV_STAGES];
  logic                  dv_zero_r [sca_pkg::DIV_STAGES];
  sca_pkg::sca_dv_t      dv_st_r   [sca_pkg::DIV_STAGES];
  logic [7:0]            dv_bits_r [sca_pkg::DIV_STAGES-1];

  // Ease-out stages.
  logic        m1_v_r, m1_in_r, m1_zero_r, m2_v_r;
  logic [8:0]  u_nxt;
  logic [16:0] uu1_r;
  logic [24:0] prod_nxt;
  logic [7:0]  alpha2_r, alpha_nxt;

  // Distance from each pixel center to the tile corner, clamped at zero.
  always_comb begin
    logic [15:0] w_edge, h_edge, cx, cy;
    w_edge = {cfg.width, 8'd0};
    h_edge = {cfg.height, 8'd0};
    cx     = {1'b0, in_col, 8'h80};
    cy     = {1'b0, in_row, 8'h80};
    dx1_nxt = (w_edge > cx) ? 15'(w_edge - cx) : 15'd0;
    dy1_nxt = (h_edge > cy) ? 15'(h_edge - cy) : 15'd0;
  end

  // Front stages payload.
  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r  <= dx1_nxt;
      dy1_r  <= dy1_nxt;
      dxx2_r <= {15'd0, dx1_r} * {15'd0, dx1_r};
      dyy2_r <= {15'd0, dy1_r} * {15'd0, dy1_r};
      sum3_r <= {1'b0, dxx2_r} + {1'b0, dyy2_r};
    end
  end

  // Front stages valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Square root, two root bits per stage, radicand shifted up as it is consumed.
  for (genvar k = 0; k < sca_pkg::SQ_STAGES; k++) begin : g_sq
    logic             v_in;
    logic [31:0]      val_in;
    sca_pkg::sca_sq_t st_in, st_mid, st_nxt;

    if (k == 0) begin : g_first
      assign v_in   = v3_r;
      assign val_in = {1'b0, sum3_r};
      assign st_in  = '0;
    end else begin : g_next
      assign v_in   = sq_v_r[k-1];
      assign val_in = sq_val_r[k-1];
      assign st_in  = sq_st_r[k-1];
    end

    assign st_mid = sca_pkg::sqrt_step(st_in, val_in[31:30]);
    assign st_nxt = sca_pkg::sqrt_step(st_mid, val_in[29:28]);

    always_ff @(posedge clk) begin
      if (en) begin
        sq_st_r[k] <= st_nxt;
      end
    end

    if (k < sca_pkg::SQ_STAGES - 1) begin : g_val
      always_ff @(posedge clk) begin
        if (en) begin
          sq_val_r[k] <= {val_in[27:0], 4'd0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (en) begin
        sq_v_r[k] <= v_in;
      end
    end
  end

  // Blur width in pixels; the user must hold the configuration still while items are in flight (not enforced here).
  assign blur_pos = cfg.width > cfg.radius;
  assign blur_div = cfg.width - cfg.radius;

  // Signed distance past the rounded corner and the two saturating cases.
  always_comb begin
    dist_nxt = {2'b00, sq_st_r[sca_pkg::SQ_STAGES-1].root} - {2'b00, cfg.radius, 8'd0};
    in_nxt   = dist_nxt[17] || (dist_nxt == 18'd0);
    zero_nxt = !blur_pos || (!dist_nxt[17] && (dist_nxt[16:0] >= {1'b0, blur_div, 8'd0}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_in_r   <= in_nxt;
      sd_zero_r <= zero_nxt;
      sd_num_r  <= dist_nxt[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_v_r <= 1'b0;
    end else if (en) begin
      sd_v_r <= sq_v_r[sca_pkg::SQ_STAGES-1];
    end
  end

  // Divide distance by blur width, two quotient bits per stage.
  for (genvar j = 0; j < sca_pkg::DIV_STAGES; j++) begin : g_dv
    logic             v_in, in_in, zero_in;
    logic [7:0]       bits_in;
    sca_pkg::sca_dv_t st_in, st_mid, st_nxt;

    if (j == 0) begin : g_first
      assign v_in    = sd_v_r;
      assign in_in   = sd_in_r;
      assign zero_in = sd_zero_r;
      assign bits_in = sd_num_r[7:0];
      assign st_in   = '{rem: {1'b0, sd_num_r[14:8]}, quo: 8'd0};
    end else begin : g_next
      assign v_in    = dv_v_r[j-1];
      assign in_in   = dv_in_r[j-1];
      assign zero_in = dv_zero_r[j-1];
      assign bits_in = dv_bits_r[j-1];
      assign st_in   = dv_st_r[j-1];
    end

    assign st_mid = sca_pkg::div_step(st_in, bits_in[7], blur_div);
    assign st_nxt = sca_pkg::div_step(st_mid, bits_in[6], blur_div);

    always_ff @(posedge clk) begin
      if (en) begin
        dv_st_r[j]   <= st_nxt;
        dv_in_r[j]   <= in_in;
        dv_zero_r[j] <= zero_in;
      end
    end

    if (j < sca_pkg::DIV_STAGES - 1) begin : g_bits
      always_ff @(posedge clk) begin
        if (en) begin
          dv_bits_r[j] <= {bits_in[5:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (en) begin
        dv_v_r[j] <= v_in;
      end
    end
  end

  // Quadratic ease-out: u = 256 - t, alpha = 255*u*u / 65536.
  assign u_nxt    = 9'd256 - {1'b0, dv_st_r[sca_pkg::DIV_STAGES-1].quo};
  assign prod_nxt = {uu1_r, 8'd0} - {8'd0, uu1_r};

  always_comb begin
    if (m1_in_r) begin
      alpha_nxt = 8'd255;
    end else if (m1_zero_r) begin
      alpha_nxt = 8'd0;
    end else begin
      alpha_nxt = prod_nxt[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uu1_r     <= {8'd0, u_nxt} * {8'd0, u_nxt};
      m1_in_r   <= dv_in_r[sca_pkg::DIV_STAGES-1];
      m1_zero_r <= dv_zero_r[sca_pkg::DIV_STAGES-1];
      alpha2_r  <= alpha_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= dv_v_r[sca_pkg::DIV_STAGES-1];
      m2_v_r <= m1_v_r;
    end
  end

  assign out_valid = m2_v_r;
  assign out_alpha = alpha2_r;

endmodule

[sv/shadow_corner_alpha_core.sv]
// Top level of the shadow corner alpha block: register port, datapath and output buffering.
// The block takes one pixel transfer per clock when the output side is not stalled and
// returns its alpha through front stages for the corner distances and their squares,
// eight square-root stages of two root bits each, one radius subtract stage, four divide
// stages of two quotient bits each, two ease-out stages and the output register. A stall
// freezes the whole datapath; a two-entry output buffer (output register plus skid stage)
// keeps in_tready a pure register output. Register values above 128 saturate when used;
// write the registers only while no pixel is in flight.
module shadow_corner_alpha_core (
  input  logic        clk,
  input  logic        rst_n,
  // Pixel input.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [6:0] col, [13:7] row, [15:14] zero
  // Alpha output.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] alpha
  // Register port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0]        width_r, height_r, radius_r;
  logic              cfg_wr;
  sca_pkg::sca_cfg_t cfg_sat;
  logic              en;
  logic              pipe_v;
  logic [7:0]        pipe_alpha;
  logic              out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  logic [7:0]        out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;
  logic              take_out;

  // Register writes complete in the access cycle.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 8'd8;
      height_r <= 8'd8;
      radius_r <= 8'd0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        sca_pkg::REG_TILE_WIDTH:    width_r  <= cfg_pwdata[7:0];
        sca_pkg::REG_TILE_HEIGHT:   height_r <= cfg_pwdata[7:0];
        sca_pkg::REG_CORNER_RADIUS: radius_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (cfg_paddr[3:2])
      sca_pkg::REG_TILE_WIDTH:    cfg_prdata = {24'd0, width_r};
      sca_pkg::REG_TILE_HEIGHT:   cfg_prdata = {24'd0, height_r};
      sca_pkg::REG_CORNER_RADIUS: cfg_prdata = {24'd0, radius_r};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  // Saturated register values for the datapath.
  assign cfg_sat.width  = sca_pkg::sat_tile(width_r);
  assign cfg_sat.height = sca_pkg::sat_tile(height_r);
  assign cfg_sat.radius = sca_pkg::sat_tile(radius_r);

  // The datapath advances whenever the skid stage is free to catch its tail.
  assign en        = !skid_v_r;
  assign in_tready = en;

  sca_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .in_col    (in_tdata[6:0]),
    .in_row    (in_tdata[13:7]),
    .cfg       (cfg_sat),
    .out_valid (pipe_v),
    .out_alpha (pipe_alpha)
  );

  // Output register with skid stage behind it.
  assign take_out = out_v_r && out_tready;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (take_out) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (pipe_v) begin
      if (!out_v_r || take_out) begin
        out_v_nxt = 1'b1;
        out_d_nxt = pipe_alpha;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = pipe_alpha;
      end
    end else if (take_out) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  // The skid stage only ever holds an item behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid stage full while output register empty");

  // The skid stage fills only when the output was stalled in the previous cycle.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid stage filled without an output stall");

  // A datapath result meeting a stalled full output must land in the skid stage.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_v && en && out_v_r && !out_tready) |=> skid_v_r)
    else $error("datapath result dropped at the output");

endmodule

[tb/tb_shadow_corner_alpha_core.sv]
// Self-checking testbench for shadow_corner_alpha_core: random pixel streams under register settings.
`timescale 1ns / 100ps

module tb_shadow_corner_alpha_core;

  // Index of a register that does not exist; writes to it must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 25;
  localparam int unsigned HOLD_CYCLES = 300;

  // Expected alphas, in transfer order, computed from the tile settings in force.
  class alpha_scoreboard;
    logic [7:0] width_q;
    logic [7:0] height_q;
    logic [7:0] radius_q;
    logic [7:0] alpha_q[$];
    int         errors;

    function new();
      width_q  = 8'd8;
      height_q = 8'd8;
      radius_q = 8'd0;
      errors   = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        sca_pkg::REG_TILE_WIDTH:    width_q = val;
        sca_pkg::REG_TILE_HEIGHT:   height_q = val;
        sca_pkg::REG_CORNER_RADIUS: radius_q = val;
        default: ;
      endcase
    endfunction

    function longint unsigned clamp_tile(logic [7:0] v);
      return (v > sca_pkg::MAX_TILE) ? longint'(sca_pkg::MAX_TILE) : longint'(v);
    endfunction

    // Distance in 1/256 pixel from the pixel center to the far tile edge, never negative.
    function longint unsigned edge_gap(longint unsigned size, logic [6:0] pos);
      longint unsigned edge_pos;
      longint unsigned center;
      edge_pos = size * 256;
      center   = longint'(pos) * 256 + 128;
      return (edge_pos > center) ? edge_pos - center : 0;
    endfunction

    function logic [7:0] corner_alpha(logic [6:0] col, logic [6:0] row);
      longint unsigned w, h, r, dx, dy, radicand, root, cand;
      longint          excess, blur, t, u;
      w  = clamp_tile(width_q);
      h  = clamp_tile(height_q);
      r  = clamp_tile(radius_q);
      dx = edge_gap(w, col);
      dy = edge_gap(h, row);
      radicand = dx * dx + dy * dy;
      // Floor square root, one root bit at a time from the top.
      root = 0;
      for (int b = 16; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= radicand) root = cand;
      end
      excess = longint'(root) - longint'(r * 256);
      blur   = (longint'(w) - longint'(r)) * 256;
      if (excess <= 0) return 8'd255;
      if (blur <= 0 || excess >= blur) return 8'd0;
      // Quadratic ease-out over the blur width.
      t = (excess * 256) / blur;
      u = 256 - t;
      return 8'((255 * u * u) / 65536);
    endfunction

    function void note_pixel(logic [15:0] data);
      alpha_q.push_back(corner_alpha(data[6:0], data[13:7]));
    endfunction

    function void check_alpha(logic [7:0] got);
      logic [7:0] want;
      if (alpha_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected alpha transfer, expected none, actual %0d", $time, got);
        return;
      end
      want = alpha_q.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: alpha mismatch, expected %0d, actual %0d", $time, want, got);
      end
    endfunction

    function int pending();
      return alpha_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [6:0] col, [13:7] row, [15:14] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // [7:0] alpha
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  alpha_scoreboard sb = new();
  int unsigned     cycles = 0;
  bit              tx_stall_on = 1'b0;
  bit              rx_stall_on = 1'b0;
  bit              rx_hold_req = 1'b0;

  shadow_corner_alpha_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL shadow_corner_alpha_core");
      $finish;
    end
  end

  // Note every accepted pixel transfer and check every accepted alpha transfer.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_tvalid && in_tready) sb.note_pixel(in_tdata);
      if (out_tvalid && out_tready) sb.check_alpha(out_tdata);
    end
  end

  // Stall length: mostly short, now and then a long one.
  function automatic int stall_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin : rx_proc
    int n;
    out_tready = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_stall_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat (stall_len()) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Offer one pixel, after an optional gap, and wait until it is taken.
  task automatic send_pixel(input logic [6:0] col, input logic [6:0] row);
    if (tx_stall_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat (stall_len()) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, row, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Random pixels, each coordinate inside the active tile half the time so the falloff is reached often.
  task automatic random_pixels(input int count);
    logic [6:0]      col;
    logic [6:0]      row;
    longint unsigned w;
    longint unsigned h;
    repeat (count) begin
      w = sb.clamp_tile(sb.width_q);
      h = sb.clamp_tile(sb.height_q);
      col = (w > 0 && $urandom_range(0, 1)) ? 7'($urandom_range(0, 32'(w - 1))) :
                                             7'($urandom_range(0, 127));
      row = (h > 0 && $urandom_range(0, 1)) ? 7'($urandom_range(0, 32'(h - 1))) :
                                             7'($urandom_range(0, 127));
      send_pixel(col, row);
    end
  endtask

  // Stop offering and wait until every expected alpha has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // New tile settings once the pipeline is empty; idling modes are redrawn too.
  task automatic retile(input logic [7:0] w, input logic [7:0] h, input logic [7:0] r);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_write(sca_pkg::REG_TILE_WIDTH, w);
    reg_write(sca_pkg::REG_TILE_HEIGHT, h);
    reg_write(sca_pkg::REG_CORNER_RADIUS, r);
    tx_stall_on = ($urandom_range(0, 3) != 0);
    rx_stall_on = ($urandom_range(0, 3) != 0);
  endtask

  initial begin : main_seq
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: tile corners, pixels past the tile and alternating bit patterns.
    send_pixel(7'd0, 7'd0);
    send_pixel(7'd7, 7'd7);
    send_pixel(7'd127, 7'd127);
    send_pixel(7'd127, 7'd0);
    send_pixel(7'd0, 7'd127);
    send_pixel(7'd6, 7'd7);
    send_pixel(7'd85, 7'd42);
    send_pixel(7'd42, 7'd85);
    tx_stall_on = 1'b1;
    rx_stall_on = 1'b1;
    random_pixels(60);

    // Largest tile; the receiver holds off while the sender keeps offering.
    retile(8'd128, 8'd128, 8'd0);
    send_pixel(7'd0, 7'd0);
    send_pixel(7'd127, 7'd127);
    tx_stall_on = 1'b0;
    rx_hold_req = 1'b1;
    random_pixels(80);
    tx_stall_on = 1'b1;
    random_pixels(40);
    // The sender pauses until every alpha is back, then resumes.
    drain();
    random_pixels(30);

    // Values above the largest tile saturate; radius equal to width leaves no blur.
    retile(8'd255, 8'd200, 8'd255);
    send_pixel(7'd127, 7'd127);
    random_pixels(50);

    // Zero width and height.
    retile(8'd0, 8'd0, 8'd0);
    send_pixel(7'd0, 7'd0);
    random_pixels(40);

    // Smallest tile.
    retile(8'd1, 8'd1, 8'd0);
    send_pixel(7'd0, 7'd0);
    random_pixels(40);

    // Rounded corner with a blur band; a write to the missing register changes nothing.
    retile(8'd16, 8'd12, 8'd6);
    reg_write(REG_UNUSED, 8'hA5);
    send_pixel(7'd15, 7'd11);
    random_pixels(70);

    // Radius at and above the width.
    retile(8'd32, 8'd32, 8'd32);
    random_pixels(60);
    retile(8'd20, 8'd24, 8'd30);
    random_pixels(60);

    // Random settings, mostly within the supported range.
    repeat (4) begin
      retile(8'($urandom_range(1, 128)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 40)));
      random_pixels(60);
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS shadow_corner_alpha_core");
    end else begin
      $display("FAIL shadow_corner_alpha_core");
    end
    $finish;
  end

endmodule
